@@ src/gf256_word_poly_inverse_check_top_assert.svh @@
// Assertion macros for the RTL.
`ifndef GF256_WORD_POLY_INVERSE_CHECK_TOP_ASSERT_SVH
`define GF256_WORD_POLY_INVERSE_CHECK_TOP_ASSERT_SVH

// Check a property while out of reset.
`define GWPI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define GWPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/gwpi_pkg.sv @@
`default_nettype none
package gwpi_pkg;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned CoefW    = 8;
  localparam int unsigned WordW    = NumLanes * CoefW;

  localparam logic [8:0] FieldPoly = 9'h11B;

  typedef logic [CoefW-1:0] coef_t;
  typedef coef_t [NumLanes-1:0] coef_word_t;

  // Lane results handed to the merge stage.
  typedef struct packed {
    logic       valid;
    coef_word_t coefs;
  } lane_out_t;

  // Multiply by x, reduce by the field polynomial.
  function automatic coef_t gf_double(input coef_t v);
    gf_double = {v[CoefW-2:0], 1'b0} ^ (v[CoefW-1] ? FieldPoly[CoefW-1:0] : coef_t'(0));
  endfunction

  // Shift-and-add product over eight doublings.
  function automatic coef_t gf_mul(input coef_t x, input coef_t y);
    coef_t acc;
    coef_t pw;
    acc = '0;
    pw  = x;
    for (int unsigned b = 0; b < CoefW; b++) begin
      if (y[b]) begin
        acc = acc ^ pw;
      end
      pw = gf_double(pw);
    end
    gf_mul = acc;
  endfunction

endpackage
`default_nettype wire

@@ src/gwpi_lane.sv @@
`default_nettype none
module gwpi_lane (
  input  wire logic                clk_i,
  input  wire logic                load_i,
  input  wire gwpi_pkg::coef_word_t rot_first_i,
  input  wire gwpi_pkg::coef_word_t second_i,
  output gwpi_pkg::coef_t          coef_o
);
  import gwpi_pkg::*;

  coef_t coef_d;
  coef_t coef_q;

  // One output coefficient: XOR of the four pairwise field products.
  always_comb begin
    coef_d = '0;
    for (int unsigned j = 0; j < NumLanes; j++) begin
      coef_d = coef_d ^ gf_mul(rot_first_i[j], second_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule
`default_nettype wire

@@ src/gwpi_merge.sv @@
`default_nettype none
module gwpi_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gwpi_pkg::lane_out_t  lanes_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [gwpi_pkg::WordW-1:0] out_word_o,
  output logic                      out_inv_o
);
  import gwpi_pkg::*;

  logic             valid_q;
  logic             valid_d;
  logic [WordW-1:0] word_q;
  logic [WordW-1:0] word_d;
  logic             inv_q;
  logic             inv_d;
  logic             take;

  assign ready_o = !valid_q || out_ready_i;
  assign take    = lanes_i.valid && ready_o;
  assign word_d  = lanes_i.coefs;
  assign inv_d   = (word_d == WordW'(1));
  assign valid_d = take || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= word_d;
      inv_q  <= inv_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;
  assign out_inv_o   = inv_q;

endmodule
`default_nettype wire

@@ src/gf256_word_poly_inverse_check_top.sv @@
// Word polynomial product over GF(2^8) modulo x^4+1, with inverse flag.
// Input stream: s_axis_tdata_i carries poly_first in bits 31:0 and
// poly_second in bits 63:32; byte k of each word is the coefficient of x^k.
// Output stream: m_axis_tdata_o carries the product word, m_axis_tuser_o
// is high when the product equals 1 (the two words are mutual inverses).
// Four lanes each form one product coefficient (four AES-field products
// XORed) and register it; a merge stage packs the coefficients, compares
// against 1 and holds the result in the output register.
// Path: a two-stage register pipeline, lane stage then output register.
// Throughput: one word per cycle unless the receiver stalls.
// Reset clears the valid bits of both stages; the data registers are not reset.
// When the receiver stalls, the output register holds its word, an empty
// lane stage still takes one more word, then s_axis_tready_o drops until
// space frees up.
`default_nettype none
module gf256_word_poly_inverse_check_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,  // [31:0] poly_first, [63:32] poly_second
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [31:0] product_word
  output logic             m_axis_tuser_o   // [0] is_inverse
);
  import gwpi_pkg::*;

  `include "gf256_word_poly_inverse_check_top_assert.svh"

  coef_word_t first_w;
  coef_word_t second_w;
  coef_word_t coefs;
  lane_out_t  lanes;
  logic       s1_valid_q;
  logic       s1_valid_d;
  logic       merge_ready;
  logic       load;

  assign first_w  = s_axis_tdata_i[WordW-1:0];
  assign second_w = s_axis_tdata_i[2*WordW-1:WordW];

  assign s_axis_tready_o = !s1_valid_q || merge_ready;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_valid_d      = load || (s1_valid_q && !merge_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    coef_word_t rot_first;
    // Lane i pairs second[j] with first[(i - j) mod 4].
    for (genvar j = 0; j < NumLanes; j++) begin : g_rot
      localparam int unsigned Src = (i + NumLanes - j) % NumLanes;
      assign rot_first[j] = first_w[Src];
    end
    gwpi_lane u_lane (
      .clk_i      (clk_i),
      .load_i     (load),
      .rot_first_i(rot_first),
      .second_i   (second_w),
      .coef_o     (coefs[i])
    );
  end

  assign lanes.valid = s1_valid_q;
  assign lanes.coefs = coefs;

  gwpi_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .lanes_i    (lanes),
    .ready_o    (merge_ready),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_word_o (m_axis_tdata_o),
    .out_inv_o  (m_axis_tuser_o)
  );

  `GWPI_ASSERT(a_flag_matches_word, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tuser_o == (m_axis_tdata_o == 32'd1)), "inverse flag disagrees with product word")
  `GWPI_ASSERT(a_accept_fills_stage, clk_i, rst_ni, load |=> s1_valid_q, "accepted word lost at lane stage")
  `GWPI_ASSERT(a_empty_stage_ready, clk_i, rst_ni, !s1_valid_q |-> s_axis_tready_o, "input stalled with empty lane stage")
  // Valid is cleared asynchronously while reset is low; check it at the edge after each reset cycle.
  `GWPI_ASSERT_ALWAYS(a_reset_clears_out, clk_i, !rst_ni |=> !m_axis_tvalid_o, "output valid after a reset cycle")

endmodule
`default_nettype wire
